// ===== src/bfm_pkg.sv =====
// ----------------------------------------------------------------------------
// Bloom filter membership package
// Shared codes, fixed field widths, hash constants and helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package bfm_pkg;

  // Fixed widths of the transaction fields and configuration registers.
  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned FB_W       = 13;
  localparam int unsigned HC_W       = 6;
  localparam int unsigned TWEAK_W    = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // Operation codes carried by the func field.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD   = 2'd0,
    FUNC_QUERY = 2'd1,
    FUNC_CLEAR = 2'd2
  } func_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FILTER_BYTES = 2'd0,
    CFG_HASH_COUNT   = 2'd1,
    CFG_TWEAK        = 2'd2
  } cfg_idx_e;

  // Hash constants.
  localparam logic [31:0] MM_C1     = 32'hcc9e2d51;
  localparam logic [31:0] MM_C2     = 32'h1b873593;
  localparam logic [31:0] MM_N      = 32'he6546b64;
  localparam logic [31:0] MM_F1     = 32'h85ebca6b;
  localparam logic [31:0] MM_F2     = 32'hc2b2ae35;
  localparam logic [31:0] SEED_STEP = 32'hFBA4C795;

  // Main controller states.
  typedef enum logic [3:0] {
    C_INIT,
    C_IDLE,
    C_CLEAR,
    C_SEED,
    C_HASH,
    C_MOD,
    C_RD,
    C_RMW,
    C_COUNT,
    C_RESP
  } ctl_state_e;

  // Hash unit states.
  typedef enum logic [3:0] {
    H_IDLE,
    H_READ,
    H_MUL1,
    H_MUL2,
    H_COMB,
    H_TMIX,
    H_FIN1,
    H_FIN2,
    H_FIN3
  } hash_state_e;

  // Rotate left by a constant amount.
  function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned r);
    return (x << r) | (x >> (32 - r));
  endfunction

  // Number of set bits in one filter byte.
  function automatic logic [3:0] popcount8(input logic [7:0] b);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + {3'b000, b[i]};
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== src/bfm_if.sv =====
// ----------------------------------------------------------------------------
// Bloom filter membership channels
// Request channel (key bytes and commands) and response channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface bfm_in_if import bfm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [7:0]        data_byte;
  logic              last_byte;
  logic              no_data;

  modport source (output valid, func, data_byte, last_byte, no_data, input ready);
  modport sink   (input valid, func, data_byte, last_byte, no_data, output ready);
endinterface

interface bfm_out_if;
  logic valid;
  logic ready;
  logic match;
  logic filter_empty;
  logic filter_full;
  logic status;

  modport source (output valid, match, filter_empty, filter_full, status, input ready);
  modport sink   (input valid, match, filter_empty, filter_full, status, output ready);
endinterface

`default_nettype wire

// ===== src/bfm_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bfm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ===== src/bfm_hash.sv =====
// ----------------------------------------------------------------------------
// Bloom filter hash unit
// Iterative 32-bit MurmurHash3 over the buffered key, one block per pass.
// ----------------------------------------------------------------------------
`default_nettype none

module bfm_hash import bfm_pkg::*; #(
  parameter int unsigned KLW  = 8,
  parameter int unsigned KWAW = 5
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [31:0]     seed_i,
  input  wire logic [KLW-1:0]  key_len_i,
  input  wire logic [31:0]     tail_word_i,
  output logic      [KWAW-1:0] kaddr_o,
  input  wire logic [31:0]     kdata_i,
  output logic                 done_o,
  output logic      [31:0]     hash_o
);

  hash_state_e    st_q, st_d;
  logic [31:0]    h_q, h_d, k_q, k_d;
  logic [KLW-1:0] len_q, len_d, blk_q, blk_d;
  logic           tail_q, tail_d;
  logic           done_q, done_d;

  logic [KLW-1:0] nblk;
  logic           has_tail;
  logic [31:0]    tail_mask;

  assign nblk     = len_q >> 2;
  assign has_tail = |len_q[1:0];
  assign kaddr_o  = blk_q[KWAW-1:0];
  assign done_o   = done_q;
  assign hash_o   = h_q;

  // Keep only the tail bytes that belong to the key.
  always_comb begin
    case (len_q[1:0])
      2'd1:    tail_mask = {24'h0, tail_word_i[7:0]};
      2'd2:    tail_mask = {16'h0, tail_word_i[15:0]};
      2'd3:    tail_mask = {8'h0, tail_word_i[23:0]};
      default: tail_mask = '0;
    endcase
  end

  // Sequencer: each multiplication ends in a register.
  always_comb begin
    logic [31:0] t;
    t      = '0;
    st_d   = st_q;
    h_d    = h_q;
    k_d    = k_q;
    len_d  = len_q;
    blk_d  = blk_q;
    tail_d = tail_q;
    done_d = 1'b0;
    case (st_q)
      H_IDLE: begin
        if (start_i) begin
          h_d   = seed_i;
          len_d = key_len_i;
          blk_d = '0;
          if ((key_len_i >> 2) != '0) begin
            tail_d = 1'b0;
            st_d   = H_READ;
          end else if (|key_len_i[1:0]) begin
            tail_d = 1'b1;
            st_d   = H_MUL1;
          end else begin
            st_d = H_FIN1;
          end
        end
      end
      H_READ: begin
        st_d = H_MUL1;
      end
      H_MUL1: begin
        k_d  = (tail_q ? tail_mask : kdata_i) * MM_C1;
        st_d = H_MUL2;
      end
      H_MUL2: begin
        k_d  = rotl32(k_q, 15) * MM_C2;
        st_d = tail_q ? H_TMIX : H_COMB;
      end
      H_COMB: begin
        t     = rotl32(h_q ^ k_q, 13);
        h_d   = (t << 2) + t + MM_N;
        blk_d = blk_q + KLW'(1);
        if (blk_q + KLW'(1) < nblk) begin
          st_d = H_READ;
        end else if (has_tail) begin
          tail_d = 1'b1;
          st_d   = H_MUL1;
        end else begin
          st_d = H_FIN1;
        end
      end
      H_TMIX: begin
        h_d  = h_q ^ k_q;
        st_d = H_FIN1;
      end
      H_FIN1: begin
        t    = h_q ^ 32'(len_q);
        t    = t ^ (t >> 16);
        h_d  = t * MM_F1;
        st_d = H_FIN2;
      end
      H_FIN2: begin
        t    = h_q ^ (h_q >> 13);
        h_d  = t * MM_F2;
        st_d = H_FIN3;
      end
      H_FIN3: begin
        h_d    = h_q ^ (h_q >> 16);
        done_d = 1'b1;
        st_d   = H_IDLE;
      end
      default: begin
        st_d = H_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= H_IDLE;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      done_q <= done_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    h_q    <= h_d;
    k_q    <= k_d;
    len_q  <= len_d;
    blk_q  <= blk_d;
    tail_q <= tail_d;
  end

endmodule

`default_nettype wire

// ===== src/bfm_mod.sv =====
// ----------------------------------------------------------------------------
// Bloom filter position reducer
// Restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bfm_mod #(
  parameter int unsigned BW = 16,
  parameter int unsigned PW = 15
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [31:0]   dividend_i,
  input  wire logic [BW-1:0] modulus_i,
  output logic               done_o,
  output logic      [PW-1:0] rem_o
);

  logic          busy_q, done_q;
  logic [4:0]    cnt_q;
  logic [31:0]   dvd_q;
  logic [BW:0]   rem_q;
  logic [BW-1:0] mod_q;
  logic [BW:0]   sh;

  assign sh     = {rem_q[BW-1:0], dvd_q[31]};
  assign done_o = done_q;
  assign rem_o  = rem_q[PW-1:0];

  // Iteration control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Shift in one bit, subtract the modulus when it fits.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvd_q <= dividend_i;
      mod_q <= modulus_i;
    end else if (busy_q) begin
      dvd_q <= dvd_q << 1;
      rem_q <= (sh >= {1'b0, mod_q}) ? sh - {1'b0, mod_q} : sh;
    end
  end

endmodule

`default_nettype wire

// ===== src/bloom_filter_murmur3_membership.sv =====
// ----------------------------------------------------------------------------
// Bloom filter membership block
// Buffers key bytes, hashes the key at its end and sets or tests filter bits.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Transaction
//   in_i      sink       one key byte, a key end, or a clear command
//   out_o     source     one response per key end or clear
//   cfg_*     input      register write, taken whenever cfg_we_i is high
//
// A key byte that does not end a key is taken without leaving the idle state. A
// key end runs, per hash, the seed step, the hash over each 4-byte block and a
// partial tail block, the finish, the remainder unit and the filter
// read-modify-write. An add then recounts the bytes in use at one byte per
// cycle. A clear sweeps all MAX_FILTER_BYTES bytes, and after reset the same
// clearing pass sweeps them while no request is accepted. A waiting response
// holds only the next response, never key bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module bloom_filter_murmur3_membership import bfm_pkg::*; #(
  parameter int unsigned MAX_FILTER_BYTES = 4096,
  parameter int unsigned MAX_HASHES       = 50,
  parameter int unsigned MAX_KEY_BYTES    = 128
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  bfm_in_if.sink                     in_i,
  bfm_out_if.source                  out_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned AW     = (MAX_FILTER_BYTES > 1) ? $clog2(MAX_FILTER_BYTES) : 1;
  localparam int unsigned CW     = $clog2(MAX_FILTER_BYTES + 1);
  localparam int unsigned BW     = $clog2(MAX_FILTER_BYTES * 8 + 1);
  localparam int unsigned PW     = $clog2(MAX_FILTER_BYTES * 8);
  localparam int unsigned KLW    = $clog2(MAX_KEY_BYTES + 1);
  localparam int unsigned KWORDS = (MAX_KEY_BYTES + 3) / 4;
  localparam int unsigned KWAW   = (KWORDS > 1) ? $clog2(KWORDS) : 1;

  // Configuration registers.
  logic [FB_W-1:0]    filter_bytes_q;
  logic [HC_W-1:0]    hash_count_q;
  logic [TWEAK_W-1:0] tweak_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_bytes_q <= FB_W'(1);
      hash_count_q   <= '0;
      tweak_q        <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FILTER_BYTES: filter_bytes_q <= cfg_wdata_i[FB_W-1:0];
        CFG_HASH_COUNT:   hash_count_q   <= cfg_wdata_i[HC_W-1:0];
        CFG_TWEAK:        tweak_q        <= cfg_wdata_i[TWEAK_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective size and hash count.
  logic [CW-1:0]   nbytes;
  logic [BW-1:0]   nbits;
  logic [HC_W-1:0] nh;

  always_comb begin
    if (filter_bytes_q == '0) begin
      nbytes = CW'(1);
    end else if (32'(filter_bytes_q) > MAX_FILTER_BYTES) begin
      nbytes = CW'(MAX_FILTER_BYTES);
    end else begin
      nbytes = CW'(filter_bytes_q);
    end
    nh = (32'(hash_count_q) > MAX_HASHES) ? HC_W'(MAX_HASHES) : hash_count_q;
  end

  assign nbits = BW'(nbytes) << 3;

  // State registers.
  ctl_state_e      st_q, st_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            rdv_q, rdv_d;
  logic [HC_W-1:0] hrem_q, hrem_d;
  logic [31:0]     seed_q, seed_d;
  logic [PW-1:0]   pos_q, pos_d;
  logic            match_q, match_d;
  logic            status_q, status_d;
  logic            op_add_q, op_add_d;
  logic [BW-1:0]   total_q, total_d;
  logic            is_empty_q, is_empty_d;
  logic [KLW-1:0]  key_len_q, key_len_d;
  logic            key_ovf_q, key_ovf_d;
  logic [31:0]     wbuf_q, wbuf_d;
  logic            ov_q, ov_d;
  logic            out_load;
  logic            full;

  assign full = (total_q == nbits);

  // Memories and units.
  logic            f_we;
  logic [AW-1:0]   f_waddr, f_raddr, pos_addr;
  logic [7:0]      f_wdata, f_rdata, bit_mask;
  logic            k_we;
  logic [KWAW-1:0] k_waddr, k_raddr;
  logic [31:0]     k_wdata, k_rdata;
  logic            hash_start, hash_done, mod_done;
  logic [31:0]     hash_val;
  logic [PW-1:0]   mod_rem;

  assign pos_addr = AW'(pos_q >> 3);
  assign bit_mask = 8'(1) << pos_q[2:0];

  bfm_ram #(.WIDTH(8), .DEPTH(MAX_FILTER_BYTES)) u_filter_ram (
    .clk_i   (clk_i),
    .we_i    (f_we),
    .waddr_i (f_waddr),
    .wdata_i (f_wdata),
    .raddr_i (f_raddr),
    .rdata_o (f_rdata)
  );

  bfm_ram #(.WIDTH(32), .DEPTH(KWORDS)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (k_we),
    .waddr_i (k_waddr),
    .wdata_i (k_wdata),
    .raddr_i (k_raddr),
    .rdata_o (k_rdata)
  );

  bfm_hash #(.KLW(KLW), .KWAW(KWAW)) u_hash (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (hash_start),
    .seed_i      (seed_q),
    .key_len_i   (key_len_q),
    .tail_word_i (wbuf_q),
    .kaddr_o     (k_raddr),
    .kdata_i     (k_rdata),
    .done_o      (hash_done),
    .hash_o      (hash_val)
  );

  bfm_mod #(.BW(BW), .PW(PW)) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (hash_done),
    .dividend_i (hash_val),
    .modulus_i  (nbits),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  assign in_i.ready = (st_q == C_IDLE);

  // Controller: next state, memory accesses and response.
  always_comb begin
    logic            accept;
    logic [31:0]     new_word;
    logic [KLW-1:0]  len_end;
    logic            ovf_end;
    accept     = in_i.valid && (st_q == C_IDLE);
    new_word   = wbuf_q;
    len_end    = key_len_q;
    ovf_end    = key_ovf_q;
    st_d       = st_q;
    cnt_d      = cnt_q;
    rdv_d      = 1'b0;
    hrem_d     = hrem_q;
    seed_d     = seed_q;
    pos_d      = pos_q;
    match_d    = match_q;
    status_d   = status_q;
    op_add_d   = op_add_q;
    total_d    = total_q;
    is_empty_d = is_empty_q;
    key_len_d  = key_len_q;
    key_ovf_d  = key_ovf_q;
    wbuf_d     = wbuf_q;
    out_load   = 1'b0;
    hash_start = 1'b0;
    f_we       = 1'b0;
    f_waddr    = pos_addr;
    f_wdata    = '0;
    f_raddr    = (st_q == C_COUNT) ? cnt_q[AW-1:0] : pos_addr;
    k_we       = 1'b0;
    k_waddr    = KWAW'(key_len_q >> 2);
    new_word[8*key_len_q[1:0] +: 8] = in_i.data_byte;
    k_wdata    = new_word;

    case (st_q)
      // Clearing pass after reset.
      C_INIT: begin
        f_we    = 1'b1;
        f_waddr = cnt_q[AW-1:0];
        cnt_d   = cnt_q + CW'(1);
        if (cnt_q == CW'(MAX_FILTER_BYTES - 1)) begin
          cnt_d = '0;
          st_d  = C_IDLE;
        end
      end
      C_IDLE: begin
        if (accept) begin
          case (in_i.func)
            FUNC_CLEAR: begin
              cnt_d      = '0;
              key_len_d  = '0;
              key_ovf_d  = 1'b0;
              is_empty_d = 1'b1;
              total_d    = '0;
              match_d    = 1'b0;
              status_d   = 1'b0;
              st_d       = C_CLEAR;
            end
            FUNC_ADD, FUNC_QUERY: begin
              // Buffer the byte; a full word goes to the key memory.
              if (!in_i.no_data) begin
                if (key_len_q < KLW'(MAX_KEY_BYTES)) begin
                  wbuf_d    = new_word;
                  key_len_d = key_len_q + KLW'(1);
                  k_we      = (key_len_q[1:0] == 2'd3);
                end else begin
                  key_ovf_d = 1'b1;
                end
              end
              len_end = key_len_d;
              ovf_end = key_ovf_d;
              // Key end: decide what work the key needs.
              if (in_i.no_data || in_i.last_byte) begin
                match_d  = 1'b0;
                status_d = 1'b0;
                op_add_d = (in_i.func == FUNC_ADD);
                seed_d   = tweak_q;
                hrem_d   = nh;
                cnt_d    = '0;
                if (ovf_end) begin
                  status_d = 1'b1;
                  st_d     = C_RESP;
                end else if (in_i.func == FUNC_ADD) begin
                  if (len_end != '0) begin
                    is_empty_d = 1'b0;
                    if (nh != '0) begin
                      st_d = C_SEED;
                    end else begin
                      total_d = '0;
                      st_d    = C_COUNT;
                    end
                  end else begin
                    st_d = C_RESP;
                  end
                end else begin
                  if (full) begin
                    match_d = 1'b1;
                    st_d    = C_RESP;
                  end else if (is_empty_q || len_end == '0) begin
                    st_d = C_RESP;
                  end else begin
                    match_d = 1'b1;
                    st_d    = (nh == '0) ? C_RESP : C_SEED;
                  end
                end
              end
            end
            default: ;
          endcase
        end
      end
      C_CLEAR: begin
        f_we    = 1'b1;
        f_waddr = cnt_q[AW-1:0];
        cnt_d   = cnt_q + CW'(1);
        if (cnt_q == CW'(MAX_FILTER_BYTES - 1)) begin
          st_d = C_RESP;
        end
      end
      C_SEED: begin
        hash_start = 1'b1;
        st_d       = C_HASH;
      end
      C_HASH: begin
        if (hash_done) begin
          st_d = C_MOD;
        end
      end
      C_MOD: begin
        if (mod_done) begin
          pos_d = mod_rem;
          st_d  = C_RD;
        end
      end
      C_RD: begin
        st_d = C_RMW;
      end
      // Set or test the bit; the next hash reads long after this write.
      C_RMW: begin
        hrem_d = hrem_q - HC_W'(1);
        seed_d = seed_q + SEED_STEP;
        if (op_add_q) begin
          f_we    = 1'b1;
          f_wdata = f_rdata | bit_mask;
        end
        if (!op_add_q && (f_rdata & bit_mask) == '0) begin
          match_d = 1'b0;
          st_d    = C_RESP;
        end else if (hrem_q == HC_W'(1)) begin
          if (op_add_q) begin
            cnt_d   = '0;
            total_d = '0;
            st_d    = C_COUNT;
          end else begin
            st_d = C_RESP;
          end
        end else begin
          st_d = C_SEED;
        end
      end
      // Recount set bits over the bytes in use, one byte per cycle.
      C_COUNT: begin
        if (cnt_q < nbytes) begin
          rdv_d = 1'b1;
          cnt_d = cnt_q + CW'(1);
        end
        if (rdv_q) begin
          total_d = total_q + BW'(popcount8(f_rdata));
        end
        if (cnt_q == nbytes && !rdv_q) begin
          st_d = C_RESP;
        end
      end
      C_RESP: begin
        if (!ov_q || out_o.ready) begin
          out_load  = 1'b1;
          key_len_d = '0;
          key_ovf_d = 1'b0;
          st_d      = C_IDLE;
        end
      end
      default: begin
        st_d = C_IDLE;
      end
    endcase
  end

  assign ov_d = out_load ? 1'b1 : (ov_q && !out_o.ready);

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= C_INIT;
      cnt_q      <= '0;
      rdv_q      <= 1'b0;
      hrem_q     <= '0;
      match_q    <= 1'b0;
      status_q   <= 1'b0;
      op_add_q   <= 1'b0;
      total_q    <= '0;
      is_empty_q <= 1'b1;
      key_len_q  <= '0;
      key_ovf_q  <= 1'b0;
      ov_q       <= 1'b0;
    end else begin
      st_q       <= st_d;
      cnt_q      <= cnt_d;
      rdv_q      <= rdv_d;
      hrem_q     <= hrem_d;
      match_q    <= match_d;
      status_q   <= status_d;
      op_add_q   <= op_add_d;
      total_q    <= total_d;
      is_empty_q <= is_empty_d;
      key_len_q  <= key_len_d;
      key_ovf_q  <= key_ovf_d;
      ov_q       <= ov_d;
    end
  end

  // Payload registers.
  logic o_match_q, o_empty_q, o_full_q, o_status_q;

  always_ff @(posedge clk_i) begin
    seed_q <= seed_d;
    pos_q  <= pos_d;
    wbuf_q <= wbuf_d;
    if (out_load) begin
      o_match_q  <= match_q;
      o_empty_q  <= is_empty_q;
      o_full_q   <= full;
      o_status_q <= status_q;
    end
  end

  assign out_o.valid        = ov_q;
  assign out_o.match        = o_match_q;
  assign out_o.filter_empty = o_empty_q;
  assign out_o.filter_full  = o_full_q;
  assign out_o.status       = o_status_q;

  // An ignored key never reports a match.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.status |-> !out_o.match)
    else $error("match reported for an ignored key");

  // An empty filter has no set bits, so it cannot be full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.filter_full |-> !out_o.filter_empty)
    else $error("filter reported both full and empty");

  // The buffered key never exceeds the buffer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_len_q <= KLW'(MAX_KEY_BYTES))
    else $error("key length beyond buffer");

  // The hash unit finishes only while the controller waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hash_done |-> st_q == C_HASH)
    else $error("hash finished outside its wait state");

endmodule

`default_nettype wire
